>>> sv/skl_pkg.sv
`timescale 1ns / 1ps
// skl_pkg: constants, request and status codes and shared types of the sorted key list.
// No dependencies.
package skl_pkg;

  localparam int SKL_CAPACITY = 16;
  localparam int KEY_W        = 32;
  localparam int COUNT_OUT_W  = 5;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } skl_state_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } skl_cell_ctl_t;

endpackage

>>> sv/skl_req_if.sv
`timescale 1ns / 1ps
// skl_req_if: request channel (op, key) with valid/ready handshake.
// Depends on skl_pkg.
interface skl_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          op;
  logic signed [skl_pkg::KEY_W-1:0]    key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

>>> sv/skl_rsp_if.sv
`timescale 1ns / 1ps
// skl_rsp_if: result channel (found, status, entry_count) with valid/ready handshake.
// Depends on skl_pkg.
interface skl_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic [1:0]                          status;
  logic [skl_pkg::COUNT_OUT_W-1:0]     entry_count;

  modport source (output valid, output found, output status, output entry_count, input ready);
  modport sink   (input valid, input found, input status, input entry_count, output ready);
endinterface

>>> sv/skl_cell.sv
`timescale 1ns / 1ps
// skl_cell: one slot of the sorted list; holds a key, registers its compare flags
// and shifts keys to or from its neighbours. Depends on skl_pkg.
module skl_cell (
  input  logic                             clk,
  input  skl_pkg::skl_cell_ctl_t           ctl,
  input  logic signed [skl_pkg::KEY_W-1:0] probe,
  input  logic                             occ,
  input  logic                             left_lt,
  input  logic signed [skl_pkg::KEY_W-1:0] left_key,
  input  logic signed [skl_pkg::KEY_W-1:0] right_key,
  output logic                             lt,
  output logic                             eq,
  output logic signed [skl_pkg::KEY_W-1:0] key
);
  import skl_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      lt <= occ && (key < probe);
      eq <= occ && (key == probe);
    end
  end

  // slots at or after the insertion or deletion point move
  always_ff @(posedge clk) begin
    if (ctl.ins && !lt) begin
      key <= left_lt ? probe : left_key;
    end else if (ctl.del && !lt) begin
      key <= right_key;
    end
  end

endmodule

>>> sv/sorted_key_list_top.sv
`timescale 1ns / 1ps
// sorted_key_list_top: row of skl_cell slots keeping signed keys in ascending order.
// Each request passes through accept, parallel compare in the cells and shift update of the
// cell row with result registration; a new request is accepted only after the update commits,
// and the update waits while a previous result is still held by result back-pressure.
// Reset clears the entry count, state machine and result valid; stored keys are not cleared.
// Depends on skl_pkg, skl_req_if, skl_rsp_if, skl_cell.
module sorted_key_list_top #(
  parameter int CAPACITY = skl_pkg::SKL_CAPACITY
) (
  input  logic       clk,
  input  logic       rst,
  skl_req_if.sink    req,
  skl_rsp_if.source  rsp
);
  import skl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  skl_state_t                state;
  logic [1:0]                op;
  logic signed [KEY_W-1:0]   probe;
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;

  logic [CAPACITY-1:0]       occ_v;
  logic [CAPACITY-1:0]       lt_v;
  logic [CAPACITY-1:0]       eq_v;
  logic signed [KEY_W-1:0]   key_v [CAPACITY];

  skl_cell_ctl_t             ctl;
  logic                      commit;
  logic                      full;
  logic                      empty;
  logic                      hit;
  logic                      found_next;
  logic [1:0]                status_next;

  assign req.ready = (state == S_IDLE);
  assign commit    = (state == S_UPD) && (!rsp.valid || rsp.ready);
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign hit       = |eq_v;

  always_comb begin
    found_next  = 1'b0;
    status_next = ST_OK;
    count_next  = count;
    ctl.cmp     = (state == S_CMP);
    ctl.ins     = 1'b0;
    ctl.del     = 1'b0;
    case (op)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins    = commit;
          count_next = count + CW'(1);
        end
      end
      OP_DELETE, OP_SEARCH: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (hit) begin
          found_next = 1'b1;
          if (op == OP_DELETE) begin
            ctl.del    = commit;
            count_next = count - CW'(1);
          end
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic                    left_lt;
      logic signed [KEY_W-1:0] left_key;
      logic signed [KEY_W-1:0] right_key;

      assign occ_v[g] = (count > CW'(g));

      if (g == 0) begin : g_first
        assign left_lt  = 1'b1;
        assign left_key = probe;
      end else begin : g_mid
        assign left_lt  = lt_v[g-1];
        assign left_key = key_v[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
        assign right_key = key_v[g];
      end else begin : g_inner
        assign right_key = key_v[g+1];
      end

      skl_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .probe     (probe),
        .occ       (occ_v[g]),
        .left_lt   (left_lt),
        .left_key  (left_key),
        .right_key (right_key),
        .lt        (lt_v[g]),
        .eq        (eq_v[g]),
        .key       (key_v[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (commit) begin
            state <= S_IDLE;
            count <= count_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op    <= req.op;
      probe <= req.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (commit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.found       <= found_next;
      rsp.status      <= status_next;
      rsp.entry_count <= COUNT_OUT_W'(count_next);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !commit |=> count == $past(count))
    else $error("entry count changed outside an update");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    commit && op == OP_INSERT && full |=> count == $past(count))
    else $error("insert into a full list changed the count");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_UPD))
    else $error("result raised without an update");

endmodule

>>> verif/skl_checker.sv
`timescale 1ns / 1ps
// skl_checker: watches the request and result channels of the sorted key list, keeps its own
// ordered key store and compares every result transaction with the predicted one.
// Depends on skl_pkg, skl_req_if, skl_rsp_if.
module skl_checker (
  input  logic clk,
  input  logic rst,
  skl_req_if   req,
  skl_rsp_if   rsp,
  output int   errors,
  output int   pending
);
  import skl_pkg::*;

  typedef struct packed {
    logic                   found;
    logic [1:0]             status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } outcome_t;

  logic signed [KEY_W-1:0] list_keys [SKL_CAPACITY];
  int                      list_len;
  outcome_t                outcome_q [$];

  function automatic outcome_t apply_request(input logic [1:0] op,
                                             input logic signed [KEY_W-1:0] key);
    outcome_t res;
    int       pos;
    int       j;
    res = '0;
    res.status = ST_OK;
    pos = 0;
    while (pos < list_len && list_keys[pos] < key) pos++;
    case (op)
      OP_INSERT: begin
        if (list_len >= SKL_CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (j = list_len; j > pos; j--) list_keys[j] = list_keys[j-1];
          list_keys[pos] = key;
          list_len++;
        end
      end
      OP_DELETE, OP_SEARCH: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (pos < list_len && list_keys[pos] == key) begin
          res.found = 1'b1;
          if (op == OP_DELETE) begin
            for (j = pos; j + 1 < list_len; j++) list_keys[j] = list_keys[j+1];
            list_len--;
          end
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    res.entry_count = list_len[COUNT_OUT_W-1:0];
    return res;
  endfunction

  task automatic note_failure(input string what, input outcome_t exp, input outcome_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: expected found=%0b status=%0d count=%0d, got found=%0b status=%0d count=%0d",
               $realtime, what, exp.found, exp.status, exp.entry_count,
               got.found, got.status, got.entry_count);
  endtask

  always @(posedge clk) begin
    outcome_t got;
    outcome_t exp;
    if (rst) begin
      list_len = 0;
      outcome_q.delete();
    end else begin
      if (req.valid && req.ready) outcome_q.push_back(apply_request(req.op, req.key));
      if (rsp.valid && rsp.ready) begin
        got.found       = rsp.found;
        got.status      = rsp.status;
        got.entry_count = rsp.entry_count;
        if (outcome_q.size() == 0) begin
          note_failure("unexpected result transaction", '0, got);
        end else begin
          exp = outcome_q.pop_front();
          if (got.found !== exp.found || got.status !== exp.status ||
              got.entry_count !== exp.entry_count)
            note_failure("result mismatch", exp, got);
        end
      end
    end
    pending = outcome_q.size();
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: drives insert, delete and search requests into sorted_key_list_top with random
// gaps and result back-pressure, and gives the verdict. Depends on skl_pkg, skl_req_if,
// skl_rsp_if, skl_checker and sorted_key_list_top.
module tb_top;
  import skl_pkg::*;

  localparam logic [1:0]        OP_UNUSED = 2'd3;
  localparam logic signed [31:0] KEY_MIN  = 32'sh80000000;
  localparam logic signed [31:0] KEY_MAX  = 32'sh7FFFFFFF;
  localparam int                 STALL_LIMIT = 2000;
  localparam int                 RANDOM_ITEMS = 1050;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   stalled;
  int   gap_pct;
  int   stall_pct;
  bit   quiet;

  skl_req_if req_ch ();
  skl_rsp_if rsp_ch ();

  sorted_key_list_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  skl_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stalled <= 0;
    end else begin
      stalled <= stalled + 1;
      if (stalled >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result back-pressure
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic issue(input logic [1:0] op, input logic signed [KEY_W-1:0] key);
    if (!quiet && gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.key   <= key;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    logic signed [KEY_W-1:0] fill_keys [9];
    logic signed [KEY_W-1:0] pool [16];
    logic signed [KEY_W-1:0] key;
    logic [1:0]              op;
    int                      n;
    int                      s;
    int                      r;
    int                      kind;

    req_ch.valid = 1'b0;
    req_ch.op    = OP_INSERT;
    req_ch.key   = '0;
    gap_pct      = 0;
    stall_pct    = 0;
    quiet        = 1'b0;
    kind         = 0;
    rst          = 1'b1;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    issue(OP_SEARCH, 32'sd5);
    issue(OP_DELETE, 32'sd5);
    issue(OP_UNUSED, 32'sd7);
    fill_keys = '{KEY_MAX, 32'sd0, -32'sd1, KEY_MIN, KEY_MAX, KEY_MIN, 32'sd1,
                  32'sh55555555, 32'shAAAAAAAA};
    for (n = 0; n < SKL_CAPACITY; n++)
      issue(OP_INSERT, (n < 9) ? fill_keys[n] : $signed($urandom));
    issue(OP_INSERT, 32'sd42);
    issue(OP_SEARCH, KEY_MIN);
    issue(OP_SEARCH, 32'sd2);
    issue(OP_DELETE, KEY_MAX);
    issue(OP_DELETE, 32'sd3);
    issue(OP_UNUSED, 32'sd0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        for (s = 0; s < 16; s++) begin
          case ($urandom_range(0, 3))
            0: begin
              case ($urandom_range(0, 3))
                0: pool[s] = KEY_MIN;
                1: pool[s] = KEY_MAX;
                2: pool[s] = 32'sd0;
                default: pool[s] = -32'sd1;
              endcase
            end
            1: pool[s] = $signed($urandom_range(0, 40)) - 32'sd20;
            default: pool[s] = $signed($urandom);
          endcase
        end
      end
      if (n % 40 == 0) begin
        kind      = $urandom_range(0, 2);
        gap_pct   = 20 * $urandom_range(0, 2);
        stall_pct = 20 * $urandom_range(0, 2);
      end
      quiet = (n >= RANDOM_ITEMS - 150);
      r = $urandom_range(0, 99);
      if (r < 2) begin
        op = OP_UNUSED;
      end else begin
        case (kind)
          0: op = (r < 72) ? OP_INSERT : (r < 86) ? OP_DELETE : OP_SEARCH;
          1: op = (r < 22) ? OP_INSERT : (r < 72) ? OP_DELETE : OP_SEARCH;
          default: op = (r < 40) ? OP_INSERT : (r < 70) ? OP_DELETE : OP_SEARCH;
        endcase
      end
      key = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 15)] : $signed($urandom);
      issue(op, key);
    end
    req_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
